### hw/rtl/constraint_row_impulse_solver_macros.svh
// assertion macros shared by the solver checker
// no dependencies; expects clk and rst_n in the scope of each use
`ifndef CONSTRAINT_ROW_IMPULSE_SOLVER_MACROS_SVH
`define CONSTRAINT_ROW_IMPULSE_SOLVER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define CRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/crs_pkg.sv
// types, constants and fixed point helpers for the constraint row solver
// no dependencies; imported by every solver module
package crs_pkg;

  localparam int unsigned NUM_BODIES_DEF = 64;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned VEC_W  = 60;
  localparam int unsigned COMP_W = 20;
  localparam int unsigned SCL_W  = 32;
  localparam int unsigned SOR_W  = 18;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned LIM_W  = 64;
  localparam int unsigned MUL_W  = 33;
  localparam int unsigned PROD_W = 66;
  localparam int unsigned JV_W   = 44;
  localparam int unsigned SACC_W = 54;
  localparam int unsigned STEP_W = 3;

  localparam logic [SOR_W-1:0] SOR_RESET = 18'd65536;

  // item functions
  localparam logic [1:0] FN_SOLVE  = 2'd0;
  localparam logic [1:0] FN_PSOLVE = 2'd1;
  localparam logic [1:0] FN_WRITE  = 2'd2;
  localparam logic [1:0] FN_READ   = 2'd3;

  // body word selects
  localparam logic [3:0] SEL_LIN  = 4'd0;
  localparam logic [3:0] SEL_ANG  = 4'd1;
  localparam logic [3:0] SEL_PLIN = 4'd2;
  localparam logic [3:0] SEL_PANG = 4'd3;
  localparam logic [3:0] SEL_IM   = 4'd4;
  localparam logic [3:0] SEL_RX   = 4'd5;
  localparam logic [3:0] SEL_RY   = 4'd6;
  localparam logic [3:0] SEL_RZ   = 4'd7;

  // dot product steps
  localparam logic [STEP_W-1:0] JV_LIN_A = 3'd0;
  localparam logic [STEP_W-1:0] JV_ANG_A = 3'd1;
  localparam logic [STEP_W-1:0] JV_LIN_B = 3'd2;
  localparam logic [STEP_W-1:0] JV_LAST  = 3'd4;

  // body update steps
  localparam logic [STEP_W-1:0] UPD_IM   = 3'd0;
  localparam logic [STEP_W-1:0] UPD_ANG  = 3'd1;
  localparam logic [STEP_W-1:0] UPD_LIN  = 3'd2;
  localparam logic [STEP_W-1:0] UPD_RX   = 3'd3;
  localparam logic [STEP_W-1:0] UPD_RY   = 3'd4;
  localparam logic [STEP_W-1:0] UPD_RZ   = 3'd5;
  localparam logic [STEP_W-1:0] UPD_LAST = 3'd6;

  localparam logic signed [PROD_W-1:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [PROD_W-1:0] S32_MIN = -66'sd2147483648;
  localparam logic signed [PROD_W-1:0] S20_MAX = 66'sd524287;
  localparam logic signed [PROD_W-1:0] S20_MIN = -66'sd524288;

  // one body row of the table
  typedef struct packed {
    logic [VEC_W-1:0] lin;
    logic [VEC_W-1:0] ang;
    logic [VEC_W-1:0] plin;
    logic [VEC_W-1:0] pang;
    logic [SCL_W-1:0] im;
    logic [VEC_W-1:0] rx;
    logic [VEC_W-1:0] ry;
    logic [VEC_W-1:0] rz;
  } row_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RDA, ST_RDB, ST_LATB, ST_JV, ST_RAW, ST_CLAMP,
    ST_SOR, ST_DELTA, ST_LOAD, ST_UPD, ST_WB, ST_WORD, ST_DONE
  } crs_state_t;

  // status into the sequencer
  typedef struct packed {
    logic in_fire;
    logic word_op;
    logic delta_zero;
    logic cur_static;
    logic clear_done;
    logic out_free;
  } stat_t;

  // control out of the sequencer
  typedef struct packed {
    crs_state_t        st;
    logic [STEP_W-1:0] step;
    logic              on_b;
    logic              ready;
    logic              clearing;
  } ctl_t;

  function automatic logic signed [COMP_W-1:0] comp20(input logic [VEC_W-1:0] w,
                                                      input int unsigned i);
    comp20 = w[COMP_W*i +: COMP_W];
  endfunction

  function automatic logic signed [SCL_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    if (v > S32_MAX) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < S32_MIN) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[SCL_W-1:0];
    end
  endfunction

  function automatic logic signed [COMP_W-1:0] sat20(input logic signed [PROD_W-1:0] v);
    if (v > S20_MAX) begin
      sat20 = 20'sh7FFFF;
    end else if (v < S20_MIN) begin
      sat20 = 20'sh80000;
    end else begin
      sat20 = v[COMP_W-1:0];
    end
  endfunction

endpackage

### hw/rtl/crs_mul3.sv
// three-lane signed multiplier with registered products
// depends on crs_pkg
module crs_mul3 (
  input  logic                              clk,
  input  logic signed [crs_pkg::MUL_W-1:0]  op_a [3],
  input  logic signed [crs_pkg::MUL_W-1:0]  op_b [3],
  output logic signed [crs_pkg::PROD_W-1:0] prod [3]
);
  import crs_pkg::*;

  logic signed [PROD_W-1:0] prod_r [3];

  // one product per lane, registered
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod_r[i] <= PROD_W'(op_a[i]) * PROD_W'(op_b[i]);
    end
  end

  assign prod = prod_r;

endmodule

### hw/rtl/crs_body_mem.sv
// body table: one synchronous memory, one write and one read port
// depends on crs_pkg
module crs_body_mem #(
  parameter int unsigned NUM_BODIES = crs_pkg::NUM_BODIES_DEF,
  parameter int unsigned AW         = $clog2(NUM_BODIES)
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  crs_pkg::row_t   wr_data,
  input  logic [AW-1:0]   rd_addr,
  output crs_pkg::row_t   rd_data
);
  import crs_pkg::*;

  row_t mem [NUM_BODIES];
  row_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/crs_fsm.sv
// sequencer for clearing, solve steps, body updates and word access
// depends on crs_pkg
module crs_fsm (
  input  logic           clk,
  input  logic           rst_n,
  input  crs_pkg::stat_t stat,
  output crs_pkg::ctl_t  ctl
);
  import crs_pkg::*;

  crs_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              on_b_r, on_b_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      step_r  <= '0;
      on_b_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      on_b_r  <= on_b_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    on_b_nxt  = on_b_r;
    case (state_r)
      ST_CLEAR: begin
        if (stat.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (stat.in_fire) begin
          state_nxt = ST_RDA;
          on_b_nxt  = 1'b0;
        end
      end
      ST_RDA:   state_nxt = ST_RDB;
      ST_RDB:   state_nxt = stat.word_op ? ST_WORD : ST_LATB;
      ST_LATB: begin
        state_nxt = ST_JV;
        step_nxt  = JV_LIN_A;
      end
      ST_JV: begin
        if (step_r == JV_LAST) begin
          state_nxt = ST_RAW;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_RAW:   state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_SOR;
      ST_SOR:   state_nxt = ST_DELTA;
      ST_DELTA: state_nxt = stat.delta_zero ? ST_DONE : ST_LOAD;
      ST_LOAD: begin
        if (stat.cur_static) begin
          if (on_b_r) begin
            state_nxt = ST_DONE;
          end else begin
            on_b_nxt = 1'b1;
          end
        end else begin
          state_nxt = ST_UPD;
          step_nxt  = UPD_IM;
        end
      end
      ST_UPD: begin
        if (step_r == UPD_LAST) begin
          state_nxt = ST_WB;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_WB: begin
        if (on_b_r) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_LOAD;
          on_b_nxt  = 1'b1;
        end
      end
      ST_WORD:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl.st       = state_r;
    ctl.step     = step_r;
    ctl.on_b     = on_b_r;
    ctl.ready    = (state_r == ST_IDLE);
    ctl.clearing = (state_r == ST_CLEAR);
  end

endmodule

### hw/rtl/constraint_row_impulse_solver.sv
// Constraint row impulse solver, top level.
// Depends on crs_pkg, crs_body_mem, crs_mul3 and crs_fsm.
//
// Input words arrive on in_valid/in_stall; a word is taken when in_valid is
// high and in_stall is low. Each word yields exactly one result word on
// out_valid/out_stall, in order. cfg_wr_en writes sor_factor; the user must
// do this only while idle, as the block itself does not enforce it.
// Words are processed one at a time; all body state sits in a single
// synchronous memory read and written through a three-lane multiplier.
//   write/read word : row reads, word access, then the result
//   solve, no change: row reads, dot product, clamp and relaxation
//   solve, updates  : plus load, update, write back per non-static body
// The order of steps follows from the shared multiplier and the memory port.
// The result sits in an output register; the next word is taken as soon as
// the sequencer is back in idle, while that result waits for the receiver.
// When the receiver stalls with a result already held, a finished word waits
// in the sequencer until the output register frees.
// Reset: synchronous, active low. After reset a clearing pass writes zero
// to every body row, one row a cycle, with in_stall high.
module constraint_row_impulse_solver #(
  parameter int unsigned NUM_BODIES = crs_pkg::NUM_BODIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [crs_pkg::SOR_W-1:0]          cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_func,
  input  logic [crs_pkg::IDX_W-1:0]          in_body_a,
  input  logic [crs_pkg::IDX_W-1:0]          in_body_b,
  input  logic [crs_pkg::VEC_W-1:0]          in_lin_a,
  input  logic [crs_pkg::VEC_W-1:0]          in_ang_a,
  input  logic [crs_pkg::VEC_W-1:0]          in_lin_b,
  input  logic [crs_pkg::VEC_W-1:0]          in_ang_b,
  input  logic signed [crs_pkg::SCL_W-1:0]   in_bias_term,
  input  logic signed [crs_pkg::SCL_W-1:0]   in_effective_mass,
  input  logic [crs_pkg::LIM_W-1:0]          in_impulse_limits,
  input  logic signed [crs_pkg::SCL_W-1:0]   in_acc_impulse,
  input  logic [crs_pkg::WORD_W-1:0]         in_body_word,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [crs_pkg::SCL_W-1:0]   out_impulse_delta,
  output logic signed [crs_pkg::SCL_W-1:0]   out_new_acc_impulse,
  output logic [crs_pkg::VEC_W-1:0]          out_read_data
);
  import crs_pkg::*;

  localparam int unsigned AW = $clog2(NUM_BODIES);

  stat_t stat;
  ctl_t  ctl;

  // registered item
  logic [1:0]              func_r;
  logic [IDX_W-1:0]        a_r, b_r;
  logic [VEC_W-1:0]        lin_a_r, ang_a_r, lin_b_r, ang_b_r;
  logic signed [SCL_W-1:0] bias_r, em_r, acc_r;
  logic [LIM_W-1:0]        lim_r;
  logic [WORD_W-1:0]       word_r;

  // working registers
  row_t                     rowa_r, rowb_r, cur_r;
  logic signed [JV_W-1:0]   jv_r;
  logic signed [MUL_W-1:0]  diff_r;
  logic signed [SCL_W-1:0]  delta_r, nacc_r, k_r;
  logic signed [SCL_W-1:0]  t_r [3];
  logic signed [COMP_W-1:0] nlin_r [3];
  logic signed [SACC_W-1:0] sacc_r [3];
  logic [VEC_W-1:0]         rdata_r;
  logic [SOR_W-1:0]         sor_r;
  logic [AW-1:0]            clr_cnt_r;

  // output register
  logic                     out_valid_r;
  logic signed [SCL_W-1:0]  out_delta_r, out_nacc_r;
  logic [VEC_W-1:0]         out_rdata_r;

  // memory and multiplier hookup
  logic                     mem_wr_en;
  logic [AW-1:0]            mem_wr_addr, mem_rd_addr;
  row_t                     mem_wr_data, mem_q;
  logic signed [MUL_W-1:0]  op_a [3];
  logic signed [MUL_W-1:0]  op_b [3];
  logic signed [PROD_W-1:0] prod [3];

  // derived values
  logic                     pseudo, a_ok, b_ok, word_sel_ok;
  logic [3:0]               word_sel;
  logic [IDX_W-1:0]         cur_idx;
  logic [VEC_W-1:0]         jl, ja, cur_vl, cur_va, jv_j, jv_v;
  row_t                     load_src, wb_row, word_row;
  logic signed [SCL_W-1:0]  s_c, raw_c, cand0_c, cand1_c, cand2_c, lower_c, upper_c;
  logic signed [SCL_W-1:0]  delta_c, nacc_c;
  logic signed [MUL_W-1:0]  neg_s_c;
  logic                     in_fire, out_free;

  function automatic logic [VEC_W-1:0] vel_lin(input row_t r, input logic ps);
    vel_lin = ps ? r.plin : r.lin;
  endfunction

  function automatic logic [VEC_W-1:0] vel_ang(input row_t r, input logic ps);
    vel_ang = ps ? r.pang : r.ang;
  endfunction

  crs_fsm u_fsm (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .ctl  (ctl)
  );

  crs_body_mem #(
    .NUM_BODIES(NUM_BODIES),
    .AW        (AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_q)
  );

  crs_mul3 u_mul (
    .clk (clk),
    .op_a(op_a),
    .op_b(op_b),
    .prod(prod)
  );

  // handshake
  assign in_fire   = in_valid && ctl.ready;
  assign in_stall  = !ctl.ready;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_impulse_delta   = out_delta_r;
  assign out_new_acc_impulse = out_nacc_r;
  assign out_read_data       = out_rdata_r;

  // item decode
  assign pseudo      = (func_r == FN_PSOLVE);
  assign a_ok        = (32'(a_r) < NUM_BODIES);
  assign b_ok        = (32'(b_r) < NUM_BODIES);
  assign word_sel    = word_r[WORD_W-1 -: 4];
  assign word_sel_ok = (word_sel <= SEL_RZ);
  assign cur_idx     = ctl.on_b ? b_r : a_r;
  assign jl          = ctl.on_b ? lin_b_r : lin_a_r;
  assign ja          = ctl.on_b ? ang_b_r : ang_a_r;
  assign cur_vl      = vel_lin(cur_r, pseudo);
  assign cur_va      = vel_ang(cur_r, pseudo);
  assign load_src    = ctl.on_b ? rowb_r : rowa_r;
  assign lower_c     = $signed(lim_r[LIM_W-1 -: SCL_W]);
  assign upper_c     = $signed(lim_r[SCL_W-1:0]);

  // sequencer status
  always_comb begin
    stat.in_fire    = in_fire;
    stat.word_op    = func_r[1];
    stat.delta_zero = (delta_c == '0);
    stat.cur_static = ($signed(load_src.im) <= 0);
    stat.clear_done = (clr_cnt_r == AW'(NUM_BODIES - 1));
    stat.out_free   = out_free;
  end

  // dot product operand select
  always_comb begin
    case (ctl.step)
      JV_LIN_A: begin
        jv_j = lin_a_r;
        jv_v = vel_lin(rowa_r, pseudo);
      end
      JV_ANG_A: begin
        jv_j = ang_a_r;
        jv_v = vel_ang(rowa_r, pseudo);
      end
      JV_LIN_B: begin
        jv_j = lin_b_r;
        jv_v = vel_lin(rowb_r, pseudo);
      end
      default: begin
        jv_j = ang_b_r;
        jv_v = vel_ang(rowb_r, pseudo);
      end
    endcase
  end

  // scalar path: bias, effective mass, clamp, relaxation
  always_comb begin
    s_c     = sat32(PROD_W'(jv_r >>> 8) + PROD_W'(bias_r));
    neg_s_c = -MUL_W'(s_c);
    raw_c   = sat32(prod[0] >>> 16);
    cand0_c = sat32(PROD_W'(acc_r) + PROD_W'(raw_c));
    cand1_c = (cand0_c < lower_c) ? lower_c : cand0_c;
    cand2_c = (cand1_c > upper_c) ? upper_c : cand1_c;
    delta_c = sat32(prod[0] >>> 16);
    nacc_c  = sat32(PROD_W'(acc_r) + PROD_W'(delta_c));
  end

  // multiplier operands
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      op_a[i] = '0;
      op_b[i] = '0;
    end
    case (ctl.st)
      ST_JV: begin
        for (int i = 0; i < 3; i++) begin
          op_a[i] = MUL_W'(comp20(jv_j, i));
          op_b[i] = MUL_W'(comp20(jv_v, i));
        end
      end
      ST_RAW: begin
        op_a[0] = neg_s_c;
        op_b[0] = MUL_W'(em_r);
      end
      ST_SOR: begin
        op_a[0] = diff_r;
        op_b[0] = MUL_W'(sor_r);
      end
      ST_UPD: begin
        case (ctl.step)
          UPD_IM: begin
            op_a[0] = MUL_W'(delta_r);
            op_b[0] = MUL_W'($signed(cur_r.im));
          end
          UPD_ANG: begin
            for (int i = 0; i < 3; i++) begin
              op_a[i] = MUL_W'(comp20(ja, i));
              op_b[i] = MUL_W'(delta_r);
            end
          end
          UPD_LIN: begin
            for (int i = 0; i < 3; i++) begin
              op_a[i] = MUL_W'(comp20(jl, i));
              op_b[i] = MUL_W'(k_r);
            end
          end
          UPD_RX: begin
            for (int j = 0; j < 3; j++) begin
              op_a[j] = MUL_W'(t_r[0]);
              op_b[j] = MUL_W'(comp20(cur_r.rx, j));
            end
          end
          UPD_RY: begin
            for (int j = 0; j < 3; j++) begin
              op_a[j] = MUL_W'(t_r[1]);
              op_b[j] = MUL_W'(comp20(cur_r.ry, j));
            end
          end
          UPD_RZ: begin
            for (int j = 0; j < 3; j++) begin
              op_a[j] = MUL_W'(t_r[2]);
              op_b[j] = MUL_W'(comp20(cur_r.rz, j));
            end
          end
          default: begin
            op_a[0] = '0;
          end
        endcase
      end
      default: begin
        op_a[0] = '0;
      end
    endcase
  end

  // updated body row for write back
  always_comb begin
    logic [VEC_W-1:0] nl, na;
    nl = '0;
    na = '0;
    for (int j = 0; j < 3; j++) begin
      nl[COMP_W*j +: COMP_W] = nlin_r[j];
      na[COMP_W*j +: COMP_W] = sat20(PROD_W'(comp20(cur_va, j)) +
                                     PROD_W'(sacc_r[j] >>> 12));
    end
    wb_row = cur_r;
    if (pseudo) begin
      wb_row.plin = nl;
      wb_row.pang = na;
    end else begin
      wb_row.lin = nl;
      wb_row.ang = na;
    end
  end

  // body word merge for writes
  always_comb begin
    word_row = rowa_r;
    case (word_sel)
      SEL_LIN:  word_row.lin  = word_r[VEC_W-1:0];
      SEL_ANG:  word_row.ang  = word_r[VEC_W-1:0];
      SEL_PLIN: word_row.plin = word_r[VEC_W-1:0];
      SEL_PANG: word_row.pang = word_r[VEC_W-1:0];
      SEL_IM:   word_row.im   = word_r[SCL_W-1:0];
      SEL_RX:   word_row.rx   = word_r[VEC_W-1:0];
      SEL_RY:   word_row.ry   = word_r[VEC_W-1:0];
      SEL_RZ:   word_row.rz   = word_r[VEC_W-1:0];
      default:  word_row = rowa_r;
    endcase
  end

  // memory port control
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = AW'(cur_idx);
    mem_wr_data = wb_row;
    mem_rd_addr = (ctl.st == ST_RDA) ? AW'(a_r) : AW'(b_r);
    if (ctl.clearing) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_cnt_r;
      mem_wr_data = '0;
    end else if (ctl.st == ST_WB) begin
      mem_wr_en = 1'b1;
    end else if (ctl.st == ST_WORD) begin
      mem_wr_en   = (func_r == FN_WRITE) && a_ok && word_sel_ok;
      mem_wr_addr = AW'(a_r);
      mem_wr_data = word_row;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sor_r       <= SOR_RESET;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) sor_r <= cfg_wr_data;
      if (ctl.clearing) clr_cnt_r <= clr_cnt_r + 1'b1;
      if ((ctl.st == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r  <= in_func;
      a_r     <= in_body_a;
      b_r     <= in_body_b;
      lin_a_r <= in_lin_a;
      ang_a_r <= in_ang_a;
      lin_b_r <= in_lin_b;
      ang_b_r <= in_ang_b;
      bias_r  <= in_bias_term;
      em_r    <= in_effective_mass;
      lim_r   <= in_impulse_limits;
      acc_r   <= in_acc_impulse;
      word_r  <= in_body_word;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      delta_r <= '0;
      nacc_r  <= '0;
      rdata_r <= '0;
    end
    // body rows, out of range bodies read as static zero rows
    if (ctl.st == ST_RDB) rowa_r <= a_ok ? mem_q : '0;
    if (ctl.st == ST_LATB) rowb_r <= b_ok ? mem_q : '0;
    // dot product accumulation
    if (ctl.st == ST_JV) begin
      if (ctl.step == JV_LIN_A) begin
        jv_r <= '0;
      end else begin
        jv_r <= jv_r + JV_W'(prod[0]) + JV_W'(prod[1]) + JV_W'(prod[2]);
      end
    end
    if (ctl.st == ST_CLAMP) diff_r <= MUL_W'(cand2_c) - MUL_W'(acc_r);
    if (ctl.st == ST_DELTA) begin
      delta_r <= delta_c;
      nacc_r  <= nacc_c;
    end
    if (ctl.st == ST_LOAD) cur_r <= load_src;
    // body update steps
    if (ctl.st == ST_UPD) begin
      case (ctl.step)
        UPD_ANG: k_r <= sat32(prod[0] >>> 16);
        UPD_LIN: begin
          for (int i = 0; i < 3; i++) t_r[i] <= sat32(prod[i] >>> 16);
        end
        UPD_RX: begin
          for (int i = 0; i < 3; i++) begin
            nlin_r[i] <= sat20(PROD_W'(comp20(cur_vl, i)) + (prod[i] >>> 16));
          end
        end
        UPD_RY: begin
          for (int j = 0; j < 3; j++) sacc_r[j] <= SACC_W'(prod[j]);
        end
        UPD_RZ, UPD_LAST: begin
          for (int j = 0; j < 3; j++) sacc_r[j] <= sacc_r[j] + SACC_W'(prod[j]);
        end
        default: begin
          k_r <= k_r;
        end
      endcase
    end
    // same body twice: B starts from A's updated row
    if ((ctl.st == ST_WB) && !ctl.on_b && (b_r == a_r)) rowb_r <= wb_row;
    // body word read
    if ((ctl.st == ST_WORD) && (func_r == FN_READ) && a_ok) begin
      case (word_sel)
        SEL_LIN:  rdata_r <= rowa_r.lin;
        SEL_ANG:  rdata_r <= rowa_r.ang;
        SEL_PLIN: rdata_r <= rowa_r.plin;
        SEL_PANG: rdata_r <= rowa_r.pang;
        SEL_IM:   rdata_r <= VEC_W'(rowa_r.im);
        SEL_RX:   rdata_r <= rowa_r.rx;
        SEL_RY:   rdata_r <= rowa_r.ry;
        SEL_RZ:   rdata_r <= rowa_r.rz;
        default:  rdata_r <= '0;
      endcase
    end
    // result word
    if ((ctl.st == ST_DONE) && out_free) begin
      out_delta_r <= delta_r;
      out_nacc_r  <= nacc_r;
      out_rdata_r <= rdata_r;
    end
  end

endmodule

### hw/rtl/crs_chk.sv
// port-level checker for the constraint row solver, bound to the top level
// depends on constraint_row_impulse_solver_macros.svh
`include "constraint_row_impulse_solver_macros.svh"

module crs_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               cfg_wr_en,
  input logic [17:0]        cfg_wr_data,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         in_func,
  input logic [5:0]         in_body_a,
  input logic [5:0]         in_body_b,
  input logic [59:0]        in_lin_a,
  input logic [59:0]        in_ang_a,
  input logic [59:0]        in_lin_b,
  input logic [59:0]        in_ang_b,
  input logic signed [31:0] in_bias_term,
  input logic signed [31:0] in_effective_mass,
  input logic [63:0]        in_impulse_limits,
  input logic signed [31:0] in_acc_impulse,
  input logic [63:0]        in_body_word,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_impulse_delta,
  input logic signed [31:0] out_new_acc_impulse,
  input logic [59:0]        out_read_data
);

  // a held result stays valid
  `CRS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  // a held result keeps its word
  `CRS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_impulse_delta) && $stable(out_new_acc_impulse) && $stable(out_read_data), "stalled result changed")

  // the clearing pass blocks input right after reset
  `CRS_ASSERT_NOW(a_clear_stall, $rose(rst_n), in_stall, "input taken during clearing")

  // one word at a time: an accept is followed by a busy cycle
  `CRS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second word taken while busy")

  // read data and impulse fields never both carry values
  `CRS_ASSERT_NOW(a_read_excl, out_valid && (out_read_data != 60'd0), (out_impulse_delta == 32'sd0) && (out_new_acc_impulse == 32'sd0), "read word with impulse values")

endmodule

bind constraint_row_impulse_solver crs_chk u_crs_chk (.*);
